// File: hw/rtl/hlsrgb_pkg.sv
`default_nettype none

package hlsrgb_pkg;

    // Q format of every channel: 1.0 is 2**FRAC_BITS
    localparam int FRAC_BITS = 12;

    // stream words are padded up to whole bytes
    function automatic int byte_pad(input int bits);
        byte_pad = ((bits + 7) / 8) * 8;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hls_to_rgb_converter_unit.sv
// Throughput: one color per cycle while the output is not stalled; four pipeline registers
// (stages one to four), one multiplier per channel in stages two and three.
// A stage takes a new word whenever it is empty or its successor takes its word, so
// bubbles are squeezed out during an output stall.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; the data registers are not reset.
`default_nettype none

module hls_to_rgb_converter_unit #(
    parameter int FRAC_BITS = hlsrgb_pkg::FRAC_BITS,
    parameter int IN_W      = hlsrgb_pkg::byte_pad(4 * FRAC_BITS + 3),
    parameter int OUT_W     = hlsrgb_pkg::byte_pad(4 * FRAC_BITS + 4)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // hue, lightness, saturation, alpha_in, zero pad
    input  wire logic [IN_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    // red, green, blue, alpha_out, zero pad
    output logic [OUT_W-1:0]      o_m_axis_tdata
);

    localparam int F = FRAC_BITS;
    localparam logic [F:0] ONE  = {1'b1, {F{1'b0}}};
    localparam logic [F:0] HALF = ONE >> 1;

    typedef enum logic [2:0] {
        SEC_RED_YEL  = 3'd0,
        SEC_YEL_GRN  = 3'd1,
        SEC_GRN_CYN  = 3'd2,
        SEC_CYN_BLU  = 3'd3,
        SEC_BLU_MAG  = 3'd4,
        SEC_MAG_RED  = 3'd5
    } t_sector;

    typedef logic [F:0] t_chan;

    // ---------------- input unpack
    logic [F-1:0] in_hue;
    t_chan        in_lum, in_sat, in_alpha;

    assign in_hue   = i_s_axis_tdata[F-1:0];
    assign in_lum   = i_s_axis_tdata[2*F:F];
    assign in_sat   = i_s_axis_tdata[3*F+1:2*F+1];
    assign in_alpha = i_s_axis_tdata[4*F+2:3*F+2];

    // ---------------- stage ready chain
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !r_v4 || i_m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_s_axis_tready = rdy1;

    // ---------------- stage 1: clamp, sector, ramps
    logic [F+2:0] h6;
    logic [F-1:0] rise;
    t_chan        fall;
    t_sector      sector;
    t_chan        n_base [3];
    t_chan        n_lum1, n_sat1;

    always_comb begin
        h6     = ({3'b0, in_hue} << 2) + ({3'b0, in_hue} << 1);
        sector = t_sector'(h6[F+2:F]);
        rise   = h6[F-1:0];
        fall   = ONE - {1'b0, rise};
        n_lum1 = (in_lum > ONE) ? ONE : in_lum;
        n_sat1 = (in_sat > ONE) ? ONE : in_sat;
        case (sector)
            SEC_RED_YEL: begin
                n_base[0] = ONE;  n_base[1] = {1'b0, rise}; n_base[2] = '0;
            end
            SEC_YEL_GRN: begin
                n_base[0] = fall; n_base[1] = ONE;          n_base[2] = '0;
            end
            SEC_GRN_CYN: begin
                n_base[0] = '0;   n_base[1] = ONE;          n_base[2] = {1'b0, rise};
            end
            SEC_CYN_BLU: begin
                n_base[0] = '0;   n_base[1] = fall;         n_base[2] = ONE;
            end
            SEC_BLU_MAG: begin
                n_base[0] = {1'b0, rise}; n_base[1] = '0;   n_base[2] = ONE;
            end
            default: begin
                n_base[0] = ONE;  n_base[1] = '0;           n_base[2] = fall;
            end
        endcase
    end

    t_chan r_base [3];
    t_chan r_lum1, r_sat1, r_alpha1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_s_axis_tvalid;
        end
        if (rdy1 && i_s_axis_tvalid) begin
            r_base   <= n_base;
            r_lum1   <= n_lum1;
            r_sat1   <= n_sat1;
            r_alpha1 <= in_alpha;
        end
    end

    // ---------------- stage 2: place around one half with span sat
    logic [2*F+1:0] sat_prod [3];
    logic [2*F+2:0] spread   [3];
    t_chan          n_c1     [3];
    t_chan          inv_sat;

    always_comb begin
        inv_sat = ONE - r_sat1;
        for (int k = 0; k < 3; k++) begin
            sat_prod[k] = {{(F+1){1'b0}}, r_base[k]} * {{(F+1){1'b0}}, r_sat1};
            spread[k]   = ({{(F+2){1'b0}}, inv_sat} << F) + {sat_prod[k], 1'b0};
            n_c1[k]     = spread[k][2*F+1:F+1];
        end
    end

    t_chan r_c1 [3];
    t_chan r_lum2, r_alpha2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
        if (rdy2 && r_v1) begin
            r_c1     <= n_c1;
            r_lum2   <= r_lum1;
            r_alpha2 <= r_alpha1;
        end
    end

    // ---------------- stage 3: scale toward black or white
    logic           dark;
    logic [F+1:0]   lum2x;
    t_chan          weight;
    t_chan          mult_a [3];
    logic [2*F+1:0] shade_prod [3];
    t_chan          n_scaled [3];

    always_comb begin
        dark   = (r_lum2 <= HALF);
        lum2x  = {r_lum2, 1'b0};
        weight = dark ? lum2x[F:0] : t_chan'(lum2x - {1'b0, ONE});
        for (int k = 0; k < 3; k++) begin
            mult_a[k]     = dark ? r_c1[k] : (ONE - r_c1[k]);
            shade_prod[k] = {{(F+1){1'b0}}, mult_a[k]} * {{(F+1){1'b0}}, weight};
            n_scaled[k]   = shade_prod[k][2*F:F];
        end
    end

    t_chan r_scaled [3];
    t_chan r_c1_3 [3];
    t_chan r_alpha3;
    logic  r_dark3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
        if (rdy3 && r_v2) begin
            r_scaled <= n_scaled;
            r_c1_3   <= r_c1;
            r_alpha3 <= r_alpha2;
            r_dark3  <= dark;
        end
    end

    // ---------------- stage 4: final add, output register
    t_chan n_out [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_out[k] = r_dark3 ? r_scaled[k] : (r_c1_3[k] + r_scaled[k]);
        end
    end

    t_chan r_out [3];
    t_chan r_alpha4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= r_v3;
        end
        if (rdy4 && r_v3) begin
            r_out    <= n_out;
            r_alpha4 <= r_alpha3;
        end
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = {{(OUT_W - 4*(F+1)){1'b0}}, r_alpha4, r_out[2], r_out[1], r_out[0]};

    // ---------------- assertions
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input blocked while pipeline has a bubble");

    a_stage1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !rdy2) |=> (r_v1 && $stable(r_lum1) && $stable(r_sat1)))
        else $error("stage 1 word lost during stall");

    a_c1_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_c1[0] <= ONE && r_c1[1] <= ONE && r_c1[2] <= ONE))
        else $error("placed channel above one");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_out[0] <= ONE && r_out[1] <= ONE && r_out[2] <= ONE))
        else $error("output channel above one");

endmodule

`default_nettype wire

// File: bench/hls_to_rgb_converter_unit_tb.sv
`timescale 1ns / 1ps

module hls_to_rgb_converter_unit_tb;

    localparam int FRAC_BITS = hlsrgb_pkg::FRAC_BITS;
    localparam int IN_W      = hlsrgb_pkg::byte_pad(4 * FRAC_BITS + 3);
    localparam int OUT_W     = hlsrgb_pkg::byte_pad(4 * FRAC_BITS + 4);
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int CH_MAX    = (1 << (FRAC_BITS + 1)) - 1;
    localparam int N_RANDOM  = 1300;
    localparam int MAX_CYCLES = 400000;

    // packed members listed from the top bits down, so the last one sits at bit 0
    typedef struct packed {
        logic [FRAC_BITS:0]   alpha_in;
        logic [FRAC_BITS:0]   saturation;
        logic [FRAC_BITS:0]   lightness;
        logic [FRAC_BITS-1:0] hue;
    } t_hls_color;

    typedef struct packed {
        logic [FRAC_BITS:0] alpha_out;
        logic [FRAC_BITS:0] blue;
        logic [FRAC_BITS:0] green;
        logic [FRAC_BITS:0] red;
    } t_rgba_color;

    typedef enum int {
        SEC_RED_GREEN_UP,
        SEC_GREEN_RED_DOWN,
        SEC_GREEN_BLUE_UP,
        SEC_BLUE_GREEN_DOWN,
        SEC_BLUE_RED_UP,
        SEC_RED_BLUE_DOWN
    } t_hue_sector;

    class color_scoreboard;
        t_rgba_color expected_rgba_q[$];
        int          mismatches;
        int          colors_in;
        int          colors_checked;
        int          over_range_in;

        function int unsigned clamp_one(int unsigned v);
            return (v > ONE) ? ONE : v;
        endfunction

        // place around one half with span sat, then darken or whiten
        function int unsigned shade(int unsigned c, int unsigned sat, int unsigned lum);
            int unsigned c1;
            int unsigned f;
            c1 = (((ONE - sat) << FRAC_BITS) + 2 * c * sat) >> (FRAC_BITS + 1);
            if (lum <= ONE / 2)
                return (c1 * 2 * lum) >> FRAC_BITS;
            f = 2 * lum - ONE;
            return c1 + (((ONE - c1) * f) >> FRAC_BITS);
        endfunction

        function t_rgba_color hls_to_rgba(t_hls_color x);
            t_rgba_color o;
            int unsigned lum, sat, h6, rise, fall, r, g, b;
            t_hue_sector sector;
            lum    = clamp_one(x.lightness);
            sat    = clamp_one(x.saturation);
            h6     = x.hue * 6;
            sector = t_hue_sector'(h6 >> FRAC_BITS);
            rise   = h6 & (ONE - 1);
            fall   = ONE - rise;
            case (sector)
                SEC_RED_GREEN_UP: begin
                    r = ONE;  g = rise; b = 0;
                end
                SEC_GREEN_RED_DOWN: begin
                    r = fall; g = ONE;  b = 0;
                end
                SEC_GREEN_BLUE_UP: begin
                    r = 0;    g = ONE;  b = rise;
                end
                SEC_BLUE_GREEN_DOWN: begin
                    r = 0;    g = fall; b = ONE;
                end
                SEC_BLUE_RED_UP: begin
                    r = rise; g = 0;    b = ONE;
                end
                default: begin
                    r = ONE;  g = 0;    b = fall;
                end
            endcase
            o.red       = (FRAC_BITS+1)'(shade(r, sat, lum));
            o.green     = (FRAC_BITS+1)'(shade(g, sat, lum));
            o.blue      = (FRAC_BITS+1)'(shade(b, sat, lum));
            o.alpha_out = x.alpha_in;
            return o;
        endfunction

        function void note_input(logic [IN_W-1:0] word);
            t_hls_color x;
            x = t_hls_color'(word[$bits(t_hls_color)-1:0]);
            if (x.lightness > ONE || x.saturation > ONE)
                over_range_in++;
            expected_rgba_q = {expected_rgba_q, hls_to_rgba(x)};
            colors_in++;
        endfunction

        task report(string what, int got, int want);
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [OUT_W-1:0] word);
            t_rgba_color got, want;
            got = t_rgba_color'(word[$bits(t_rgba_color)-1:0]);
            if (expected_rgba_q.size() == 0) begin
                report("unexpected output word", int'(got.red), 0);
                return;
            end
            want = expected_rgba_q.pop_front();
            colors_checked++;
            if (got.red !== want.red)             report("red", got.red, want.red);
            if (got.green !== want.green)         report("green", got.green, want.green);
            if (got.blue !== want.blue)           report("blue", got.blue, want.blue);
            if (got.alpha_out !== want.alpha_out) report("alpha", got.alpha_out, want.alpha_out);
            if (word[OUT_W-1:$bits(t_rgba_color)] !== '0)
                report("pad bits", word[OUT_W-1:$bits(t_rgba_color)], 0);
        endtask

        function int pending();
            return expected_rgba_q.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    // hue, lightness, saturation, alpha_in, zero pad
    logic [IN_W-1:0]  i_s_axis_tdata = '0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    // red, green, blue, alpha_out, zero pad
    logic [OUT_W-1:0] o_m_axis_tdata;

    color_scoreboard  color_sb = new();
    int               cycle_count = 0;
    int               stall_mode = 0;
    int               stall_left = 0;

    hls_to_rgb_converter_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // handshake monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            color_sb.note_input(i_s_axis_tdata);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            color_sb.check_result(o_m_axis_tdata);
    end

    // receiver: stall pattern switches between always ready, coin flip,
    // mostly stalled and an on/off rhythm taken from bit 2 of the cycle counter
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 150);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                i_m_axis_tready <= 1'b1;
            end
            1: begin
                i_m_axis_tready <= ($urandom_range(0, 1) == 1);
            end
            2: begin
                i_m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                i_m_axis_tready <= cycle_count[2];
            end
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Timeout after %0d cycles, %0d words outstanding",
                     cycle_count, color_sb.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] pack_color(int h, int l, int s, int a);
        t_hls_color x;
        x.hue        = FRAC_BITS'(h);
        x.lightness  = (FRAC_BITS+1)'(l);
        x.saturation = (FRAC_BITS+1)'(s);
        x.alpha_in   = (FRAC_BITS+1)'(a);
        return {{(IN_W - $bits(t_hls_color)){1'b0}}, x};
    endfunction

    function automatic int rand_fraction();
        // mostly legal fractions, now and then an over-range value
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, CH_MAX);
        return $urandom_range(0, ONE);
    endfunction

    task send_word(logic [IN_W-1:0] word);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task sender_gap(int n);
        if (n > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (color_sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int sent;
        int burst;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners: hue extremes and sector edges, lightness/saturation edges,
        // over-range values, alpha extremes; sent back to back
        send_word(pack_color(0,    2048, 4096, 0));
        send_word(pack_color(4095, 2048, 4096, CH_MAX));
        send_word(pack_color(682,  2048, 4096, 4096));
        send_word(pack_color(683,  2048, 4096, 1));
        send_word(pack_color(1365, 2048, 4096, 2));
        send_word(pack_color(1366, 2048, 4096, 3));
        send_word(pack_color(2048, 2048, 4096, 4));
        send_word(pack_color(2730, 2048, 4096, 5));
        send_word(pack_color(2731, 2048, 4096, 6));
        send_word(pack_color(3413, 2048, 4096, 7));
        send_word(pack_color(3414, 2048, 4096, 8));
        send_word(pack_color(1000, 0,    4096, 2730));
        send_word(pack_color(1000, 4096, 4096, 2730));
        send_word(pack_color(1000, 2049, 3000, 2730));
        send_word(pack_color(1000, 2047, 3000, 2730));
        send_word(pack_color(1000, 2048, 0,    2730));
        send_word(pack_color(3000, CH_MAX, 2000, 100));
        send_word(pack_color(3000, 4097, 2000, 100));
        send_word(pack_color(3000, 1500, CH_MAX, 100));
        send_word(pack_color(3000, 1500, 4097, 100));
        send_word(pack_color(4095, CH_MAX, CH_MAX, CH_MAX));
        send_word(pack_color(0,    0,    0,    0));
        send_word(pack_color(2500, 3000, 1, 4095));
        wait_drained();

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
                send_word(pack_color($urandom_range(0, ONE - 1), rand_fraction(),
                                     rand_fraction(), $urandom_range(0, CH_MAX)));
                sent++;
                if (sent == N_RANDOM / 2)
                    wait_drained();
            end
            // zero gap now and then keeps long unbroken streams
            sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
        i_s_axis_tvalid <= 1'b0;

        while (color_sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("Converted %0d colors (%0d with lightness or saturation above one), checked %0d",
                 color_sb.colors_in, color_sb.over_range_in, color_sb.colors_checked);
        $display("All six hue sectors, light and dark halves, bursty input and output stalls");
        if (color_sb.mismatches == 0 && color_sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
